### rtl/rv32ie_pkg.sv
`default_nettype none
package rv32ie_pkg;

    localparam int unsigned MemBytesDefault = 65536;
    localparam int unsigned ShamtW = 5;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_ADDI  = 6'd1,  OP_AND   = 6'd2,  OP_ANDI  = 6'd3,
        OP_OR    = 6'd4,  OP_ORI   = 6'd5,  OP_XOR   = 6'd6,  OP_XORI  = 6'd7,
        OP_SUB   = 6'd8,  OP_SLL   = 6'd9,  OP_SLLI  = 6'd10, OP_SRL   = 6'd11,
        OP_SRLI  = 6'd12, OP_SRA   = 6'd13, OP_SRAI  = 6'd14, OP_SLT   = 6'd15,
        OP_SLTU  = 6'd16, OP_SLTI  = 6'd17, OP_SLTIU = 6'd18, OP_BEQ   = 6'd19,
        OP_BNE   = 6'd20, OP_BLT   = 6'd21, OP_BGE   = 6'd22, OP_BLTU  = 6'd23,
        OP_BGEU  = 6'd24, OP_LB    = 6'd25, OP_LH    = 6'd26, OP_LW    = 6'd27,
        OP_LBU   = 6'd28, OP_LHU   = 6'd29, OP_SW    = 6'd30, OP_SB    = 6'd31,
        OP_SH    = 6'd32, OP_JAL   = 6'd33, OP_JALR  = 6'd34, OP_LUI   = 6'd35,
        OP_AUIPC = 6'd36, OP_ECALL = 6'd37, OP_NOP   = 6'd38
    } t_op;

    typedef enum logic [1:0] {
        SZ_B = 2'd0,
        SZ_H = 2'd1,
        SZ_W = 2'd2
    } t_size;

    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        t_size       size;
        logic [31:0] addr;
        logic [31:0] wdata;
    } t_dmem_req;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic       rd_en;
        logic [4:0] addr_a;
        logic [4:0] addr_b;
    } t_rf_rd;

endpackage
`default_nettype wire

### rtl/rv32i_instruction_execute_top.sv
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_op i_dest_reg i_src1_reg i_src2_reg i_immediate i_inst_pc
// out     | o_valid | i_stall | o_next_pc o_reg_write o_write_value o_ecall_request
//         |         |         | o_retired_count
// Three stages: register read, execute with data memory access, write-back into the
// output register. A word may enter every cycle while o_stall is low; o_valid rises
// once the word has passed stages one and two into the output register.
// Register operands forward from write-back, so dependent words do not wait.
// Reset clears the register file through per-entry valid bits; no clearing pass.
// A stall on a full output holds each full stage that cannot advance; empty stages still fill.
// o_stall rises only when stage one is full and cannot advance.
`default_nettype none
module rv32i_instruction_execute_top
    import rv32ie_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [5:0]  i_op,
    input  wire logic [4:0]  i_dest_reg,
    input  wire logic [4:0]  i_src1_reg,
    input  wire logic [4:0]  i_src2_reg,
    input  wire logic [31:0] i_immediate,
    input  wire logic [31:0] i_inst_pc,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_next_pc,
    output logic             o_reg_write,
    output logic [31:0]      o_write_value,
    output logic             o_ecall_request,
    output logic [63:0]      o_retired_count
);

    logic        r_v1, r_v2, r_vo;
    logic        out_free, s2_go, s2_free, s1_go, s1_free, acc;

    logic [5:0]  r_op;
    logic [4:0]  r_rd, r_rs1, r_rs2;
    logic [31:0] r_imm, r_pc;
    logic        r_fa_v, r_fb_v;
    logic [31:0] r_fa, r_fb;

    logic [31:0] r_s2_val, r_s2_npc;
    logic        r_s2_wr, r_s2_ecall, r_s2_ld;
    logic [5:0]  r_s2_op;
    logic [4:0]  r_s2_rd;
    logic [1:0]  r_s2_lsb;
    logic [31:0] s2_val;

    logic [63:0] r_cnt;

    t_rf_rd      rf_rd;
    t_rf_wr      rf_wr;
    t_dmem_req   dm_req;
    logic [31:0] qa, qb, dm_q;

    logic [31:0] a, b, addr, seq, val, npc;
    logic        wr, ecall, ld, st, cond;
    t_size       size;
    logic [4:0]  sh_r, sh_i;
    logic [31:0] ldw;
    logic [1:0]  lsel [4];
    logic [7:0]  lb [4];

    assign out_free = !r_vo || !i_stall;
    assign s2_go    = r_v2 && out_free;
    assign s2_free  = !r_v2 || s2_go;
    assign s1_go    = r_v1 && s2_free;
    assign s1_free  = !r_v1 || s1_go;
    assign acc      = i_valid && s1_free;
    assign o_stall  = !s1_free;

    assign rf_rd = '{rd_en: acc, addr_a: i_src1_reg, addr_b: i_src2_reg};

    rv32ie_regfile u_rf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd   (rf_rd),
        .i_wr   (rf_wr),
        .o_qa   (qa),
        .o_qb   (qb)
    );

    rv32ie_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
        .i_clk  (i_clk),
        .i_req  (dm_req),
        .o_rdata(dm_q)
    );

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            lsel[j] = 2'(j) + r_s2_lsb;
            lb[j]   = dm_q[8*lsel[j] +: 8];
        end
        ldw = {lb[3], lb[2], lb[1], lb[0]};
        s2_val = r_s2_val;
        if (r_s2_ld && r_s2_wr) begin
            unique case (r_s2_op)
                OP_LB:   s2_val = {{24{ldw[7]}}, ldw[7:0]};
                OP_LH:   s2_val = {{16{ldw[15]}}, ldw[15:0]};
                OP_LBU:  s2_val = {24'd0, ldw[7:0]};
                OP_LHU:  s2_val = {16'd0, ldw[15:0]};
                default: s2_val = ldw;
            endcase
        end
    end

    assign rf_wr = '{en: s2_go && r_s2_wr, addr: r_s2_rd, data: s2_val};

    always_comb begin
        priority if (r_rs1 == 5'd0) a = '0;
        else if (r_v2 && r_s2_wr && r_s2_rd == r_rs1) a = s2_val;
        else if (r_fa_v) a = r_fa;
        else a = qa;
        priority if (r_rs2 == 5'd0) b = '0;
        else if (r_v2 && r_s2_wr && r_s2_rd == r_rs2) b = s2_val;
        else if (r_fb_v) b = r_fb;
        else b = qb;
    end

    always_comb begin
        sh_r  = b[ShamtW-1:0];
        sh_i  = r_imm[ShamtW-1:0];
        addr  = a + r_imm;
        seq   = r_pc + 32'd4;
        npc   = seq;
        val   = '0;
        wr    = 1'b0;
        ecall = 1'b0;
        ld    = 1'b0;
        st    = 1'b0;
        cond  = 1'b0;
        size  = SZ_W;
        unique case (r_op)
            OP_ADD:   begin val = a + b; wr = 1'b1; end
            OP_ADDI:  begin val = addr; wr = 1'b1; end
            OP_AND:   begin val = a & b; wr = 1'b1; end
            OP_ANDI:  begin val = a & r_imm; wr = 1'b1; end
            OP_OR:    begin val = a | b; wr = 1'b1; end
            OP_ORI:   begin val = a | r_imm; wr = 1'b1; end
            OP_XOR:   begin val = a ^ b; wr = 1'b1; end
            OP_XORI:  begin val = a ^ r_imm; wr = 1'b1; end
            OP_SUB:   begin val = a - b; wr = 1'b1; end
            OP_SLL:   begin val = a << sh_r; wr = 1'b1; end
            OP_SLLI:  begin val = a << sh_i; wr = 1'b1; end
            OP_SRL:   begin val = a >> sh_r; wr = 1'b1; end
            OP_SRLI:  begin val = a >> sh_i; wr = 1'b1; end
            OP_SRA:   begin val = $unsigned($signed(a) >>> sh_r); wr = 1'b1; end
            OP_SRAI:  begin val = $unsigned($signed(a) >>> sh_i); wr = 1'b1; end
            OP_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; wr = 1'b1; end
            OP_SLTU:  begin val = {31'd0, a < b}; wr = 1'b1; end
            OP_SLTI:  begin val = {31'd0, $signed(a) < $signed(r_imm)}; wr = 1'b1; end
            OP_SLTIU: begin val = {31'd0, a < r_imm}; wr = 1'b1; end
            OP_BEQ:   cond = (a == b);
            OP_BNE:   cond = (a != b);
            OP_BLT:   cond = ($signed(a) < $signed(b));
            OP_BGE:   cond = !($signed(a) < $signed(b));
            OP_BLTU:  cond = (a < b);
            OP_BGEU:  cond = (a >= b);
            OP_LB, OP_LBU: begin ld = 1'b1; wr = 1'b1; size = SZ_B; end
            OP_LH, OP_LHU: begin ld = 1'b1; wr = 1'b1; size = SZ_H; end
            OP_LW:    begin ld = 1'b1; wr = 1'b1; end
            OP_SW:    st = 1'b1;
            OP_SB:    begin st = 1'b1; size = SZ_B; end
            OP_SH:    begin st = 1'b1; size = SZ_H; end
            OP_JAL:   begin val = seq; wr = 1'b1; npc = r_pc + r_imm; end
            OP_JALR:  begin val = seq; wr = 1'b1; npc = {addr[31:1], 1'b0}; end
            OP_LUI:   begin val = r_imm; wr = 1'b1; end
            OP_AUIPC: begin val = r_pc + r_imm; wr = 1'b1; end
            OP_ECALL: ecall = 1'b1;
            default:  ;
        endcase
        if (cond) begin
            npc = r_pc + r_imm;
        end
        if (r_rd == 5'd0) begin
            wr = 1'b0;
        end
        if (!wr) begin
            val = '0;
        end
    end

    assign dm_req = '{rd_en: s1_go && ld, wr_en: s1_go && st, size: size,
                      addr: addr, wdata: b};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_op;
            r_rd  <= i_dest_reg;
            r_rs1 <= i_src1_reg;
            r_rs2 <= i_src2_reg;
            r_imm <= i_immediate;
            r_pc  <= i_inst_pc;
            r_fa  <= rf_wr.data;
            r_fb  <= rf_wr.data;
        end else begin
            if (rf_wr.en && rf_wr.addr == r_rs1) begin
                r_fa <= rf_wr.data;
            end
            if (rf_wr.en && rf_wr.addr == r_rs2) begin
                r_fb <= rf_wr.data;
            end
        end
        if (s1_go) begin
            r_s2_val   <= val;
            r_s2_npc   <= npc;
            r_s2_wr    <= wr;
            r_s2_ecall <= ecall;
            r_s2_ld    <= ld;
            r_s2_op    <= r_op;
            r_s2_rd    <= r_rd;
            r_s2_lsb   <= addr[1:0];
        end
        if (s2_go) begin
            o_next_pc       <= r_s2_npc;
            o_reg_write     <= r_s2_wr;
            o_write_value   <= s2_val;
            o_ecall_request <= r_s2_ecall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vo   <= 1'b0;
            r_fa_v <= 1'b0;
            r_fb_v <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (s1_free) begin
                r_v1 <= acc;
            end
            if (s2_free) begin
                r_v2 <= s1_go;
            end
            if (out_free) begin
                r_vo <= s2_go;
            end
            if (acc) begin
                r_fa_v <= rf_wr.en && rf_wr.addr == i_src1_reg;
                r_fb_v <= rf_wr.en && rf_wr.addr == i_src2_reg;
            end else begin
                if (rf_wr.en && rf_wr.addr == r_rs1) begin
                    r_fa_v <= 1'b1;
                end
                if (rf_wr.en && rf_wr.addr == r_rs2) begin
                    r_fb_v <= 1'b1;
                end
            end
            if (s2_go) begin
                r_cnt <= r_cnt + 64'd1;
            end
        end
    end

    assign o_valid         = r_vo;
    assign o_retired_count = r_cnt;

    a_cnt_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go |=> (r_cnt == $past(r_cnt) + 64'd1))
        else $error("retired count did not advance");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> (rf_wr.addr != 5'd0))
        else $error("write to x0");

    a_quiet_when_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reg_write) |-> (o_write_value == 32'd0))
        else $error("write value without write");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v1)
        else $error("accepted word lost");

endmodule
`default_nettype wire

### rtl/rv32ie_regfile.sv
`default_nettype none
module rv32ie_regfile
    import rv32ie_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_rf_rd      i_rd,
    input  wire t_rf_wr      i_wr,
    output logic [31:0]      o_qa,
    output logic [31:0]      o_qb
);

    logic [31:0] mem [32];
    logic [31:0] r_ok;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_oka;
    logic        r_okb;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.rd_en) begin
            r_qa <= mem[i_rd.addr_a];
            r_qb <= mem[i_rd.addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok  <= '0;
            r_oka <= 1'b0;
            r_okb <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_ok[i_wr.addr] <= 1'b1;
            end
            if (i_rd.rd_en) begin
                r_oka <= r_ok[i_rd.addr_a];
                r_okb <= r_ok[i_rd.addr_b];
            end
        end
    end

    assign o_qa = r_oka ? r_qa : '0;
    assign o_qb = r_okb ? r_qb : '0;

endmodule
`default_nettype wire

### rtl/rv32ie_dmem.sv
`default_nettype none
module rv32ie_dmem
    import rv32ie_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MemBytesDefault
) (
    input  wire logic        i_clk,
    input  wire t_dmem_req   i_req,
    output logic [31:0]      o_rdata
);

    localparam int unsigned AW   = $clog2(MEM_BYTES);
    localparam int unsigned RW   = AW - 2;
    localparam int unsigned ROWS = MEM_BYTES / 4;

    logic [7:0]    mem [4][ROWS];
    logic [7:0]    r_q [4];
    logic [1:0]    lsb;
    logic [RW-1:0] row [4];
    logic [3:0]    we;
    logic [7:0]    wd  [4];
    logic [1:0]    k   [4];
    logic [2:0]    nb;

    assign lsb = i_req.addr[1:0];

    always_comb begin
        unique case (i_req.size)
            SZ_B:    nb = 3'd1;
            SZ_H:    nb = 3'd2;
            default: nb = 3'd4;
        endcase
        for (int j = 0; j < 4; j++) begin
            k[j]   = 2'(j) - lsb;
            row[j] = i_req.addr[AW-1:2] + RW'(2'(j) < lsb);
            we[j]  = i_req.wr_en && ({1'b0, k[j]} < nb);
            wd[j]  = i_req.wdata[8*k[j] +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            if (we[j]) begin
                mem[j][row[j]] <= wd[j];
            end
            if (i_req.rd_en) begin
                r_q[j] <= mem[j][row[j]];
            end
        end
    end

    assign o_rdata = {r_q[3], r_q[2], r_q[1], r_q[0]};

endmodule
`default_nettype wire
